/* src/wss_pkg.sv */
// Shared widths, types and latencies for the wall shear stress projection pipeline.
// No dependencies; imported by every module of the block.
package wss_pkg;

   localparam int DW = 32;          // width of one Q16.16 component
   localparam int PW = 2 * DW;      // product and squared-sum width
   localparam int NW = 3 * DW;      // dividend width (load dot times normal component)
   localparam int QW = DW + 1;      // quotient width
   localparam int SR = DW + 3;      // square-root partial remainder width
   localparam int DIV_LAT = QW + 2; // divider register count
   localparam int SQ_LAT = DW + 2;  // square-root register count

   typedef logic signed [DW-1:0] word_type;
   typedef logic [DW-1:0]        mag_type;
   typedef logic [PW-1:0]        wide_type;
   typedef logic [NW-1:0]        num_type;
   typedef logic [QW-1:0]        quo_type;

   // side data that rides along with the quotients
   typedef struct packed {
      logic [2:0][DW-1:0] ld;
      logic [2:0]         n_neg;
      logic               d_neg;
      logic               degen;
   } meta_type;

endpackage

/* src/wss_front.sv */
// Front end: magnitudes, squared norm, dot product and the dividends of the three projections.
// Depends on wss_pkg.
module wss_front
   import wss_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     in_valid,
   input  word_type normal [3],
   input  word_type load [3],
   output logic     out_valid,
   output num_type  num [3],
   output wide_type norm_sq,
   output meta_type meta
);

   function automatic mag_type mag_of(input word_type v);
      return v[DW-1] ? mag_type'(~v + 1'b1) : mag_type'(v);
   endfunction

   logic [5:0] v_ff;

   // stage 1
   mag_type  nmag1_ff [3];
   mag_type  lmag1_ff [3];
   logic [2:0] nneg1_ff, lneg1_ff;
   word_type ld1_ff [3];
   // stage 2
   wide_type sq2_ff [3];
   wide_type pr2_ff [3];
   logic [2:0] diff2_ff, nneg2_ff;
   mag_type  nmag2_ff [3];
   word_type ld2_ff [3];
   // stage 3
   wide_type s3_ff, pos3_ff, neg3_ff;
   logic [2:0] nneg3_ff;
   mag_type  nmag3_ff [3];
   word_type ld3_ff [3];
   // stage 4
   wide_type s4_ff, dmag4_ff;
   logic     dneg4_ff, degen4_ff;
   logic [2:0] nneg4_ff;
   mag_type  nmag4_ff [3];
   word_type ld4_ff [3];
   // stage 5
   wide_type plo5_ff [3];
   wide_type phi5_ff [3];
   wide_type s5_ff;
   logic     dneg5_ff, degen5_ff;
   logic [2:0] nneg5_ff;
   word_type ld5_ff [3];
   // stage 6
   num_type  num6_ff [3];
   wide_type s6_ff;
   meta_type meta6_ff;

   wide_type pos_in, neg_in;
   always_comb begin
      pos_in = '0;
      neg_in = '0;
      for (int i = 0; i < 3; i++) begin
         if (diff2_ff[i]) neg_in = neg_in + pr2_ff[i];
         else pos_in = pos_in + pr2_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            nmag1_ff[i] <= mag_of(normal[i]);
            lmag1_ff[i] <= mag_of(load[i]);
            nneg1_ff[i] <= normal[i][DW-1];
            lneg1_ff[i] <= load[i][DW-1];
            ld1_ff[i]   <= load[i];

            sq2_ff[i]   <= wide_type'(nmag1_ff[i]) * wide_type'(nmag1_ff[i]);
            pr2_ff[i]   <= wide_type'(nmag1_ff[i]) * wide_type'(lmag1_ff[i]);
            diff2_ff[i] <= nneg1_ff[i] ^ lneg1_ff[i];
            nneg2_ff[i] <= nneg1_ff[i];
            nmag2_ff[i] <= nmag1_ff[i];
            ld2_ff[i]   <= ld1_ff[i];

            nneg3_ff[i] <= nneg2_ff[i];
            nmag3_ff[i] <= nmag2_ff[i];
            ld3_ff[i]   <= ld2_ff[i];

            nneg4_ff[i] <= nneg3_ff[i];
            nmag4_ff[i] <= nmag3_ff[i];
            ld4_ff[i]   <= ld3_ff[i];

            plo5_ff[i]  <= wide_type'(dmag4_ff[DW-1:0]) * wide_type'(nmag4_ff[i]);
            phi5_ff[i]  <= wide_type'(dmag4_ff[PW-1:DW]) * wide_type'(nmag4_ff[i]);
            nneg5_ff[i] <= nneg4_ff[i];
            ld5_ff[i]   <= ld4_ff[i];

            num6_ff[i]  <= {{DW{1'b0}}, plo5_ff[i]} + {phi5_ff[i], {DW{1'b0}}};
            meta6_ff.ld[i]    <= ld5_ff[i];
            meta6_ff.n_neg[i] <= nneg5_ff[i];
         end
         s3_ff   <= sq2_ff[0] + sq2_ff[1] + sq2_ff[2];
         pos3_ff <= pos_in;
         neg3_ff <= neg_in;

         s4_ff     <= s3_ff;
         dneg4_ff  <= neg3_ff > pos3_ff;
         dmag4_ff  <= (neg3_ff > pos3_ff) ? neg3_ff - pos3_ff : pos3_ff - neg3_ff;
         degen4_ff <= s3_ff == '0;

         s5_ff     <= s4_ff;
         dneg5_ff  <= dneg4_ff;
         degen5_ff <= degen4_ff;

         s6_ff          <= s5_ff;
         meta6_ff.d_neg <= dneg5_ff;
         meta6_ff.degen <= degen5_ff;
      end
   end

   assign out_valid = v_ff[5];
   assign num       = num6_ff;
   assign norm_sq   = s6_ff;
   assign meta      = meta6_ff;

endmodule

/* src/wss_div.sv */
// Pipelined restoring divider, one quotient bit per stage, round to nearest ties up.
// Depends on wss_pkg.
module wss_div
   import wss_pkg::*;
(
   input  logic     clock,
   input  logic     en,
   input  num_type  num,
   input  wide_type den,
   output quo_type  quo
);

   wide_type rem_ff  [0:QW];
   quo_type  work_ff [0:QW];
   wide_type den_ff  [0:QW];
   quo_type  quo_ff;

   wide_type rem_in  [0:QW-1];
   quo_type  work_in [0:QW-1];
   quo_type  quo_in;

   always_comb begin
      for (int k = 0; k < QW; k++) begin
         logic [PW:0] r2;
         logic        ge;
         r2 = {rem_ff[k], work_ff[k][QW-1]};
         ge = r2 >= {1'b0, den_ff[k]};
         rem_in[k]  = ge ? PW'(r2 - {1'b0, den_ff[k]}) : r2[PW-1:0];
         work_in[k] = {work_ff[k][QW-2:0], ge};
      end
      quo_in = ({rem_ff[QW], 1'b0} >= {1'b0, den_ff[QW]}) ? work_ff[QW] + 1'b1
                                                          : work_ff[QW];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // high dividend bits stay below the divisor, so they seed the remainder
         rem_ff[0]  <= {1'b0, num[NW-1:QW]};
         work_ff[0] <= num[QW-1:0];
         den_ff[0]  <= den;
         for (int k = 0; k < QW; k++) begin
            rem_ff[k+1]  <= rem_in[k];
            work_ff[k+1] <= work_in[k];
            den_ff[k+1]  <= den_ff[k];
         end
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule

/* src/wss_sqrt.sv */
// Pipelined digit-by-digit square root, one result bit per stage, rounded and saturated.
// Depends on wss_pkg.
module wss_sqrt
   import wss_pkg::*;
(
   input  logic          clock,
   input  logic          en,
   input  wide_type      radicand,
   output logic [DW-2:0] root
);

   logic [SR-1:0] rem_ff  [0:DW];
   mag_type       root_ff [0:DW];
   wide_type      x_ff    [0:DW];
   logic [DW-2:0] out_ff;

   logic [SR-1:0] rem_in  [0:DW-1];
   mag_type       root_in [0:DW-1];
   wide_type      x_in    [0:DW-1];
   logic [DW:0]   up;
   logic [DW-2:0] out_in;

   always_comb begin
      for (int k = 0; k < DW; k++) begin
         logic [SR-1:0] r2, trial;
         logic          ge;
         r2    = {rem_ff[k][SR-3:0], x_ff[k][PW-1:PW-2]};
         trial = {{(SR-DW-2){1'b0}}, root_ff[k], 2'b01};
         ge    = r2 >= trial;
         rem_in[k]  = ge ? r2 - trial : r2;
         root_in[k] = {root_ff[k][DW-2:0], ge};
         x_in[k]    = {x_ff[k][PW-3:0], 2'b00};
      end
      // round up when the leftover exceeds the floor root
      up = (rem_ff[DW] > {{(SR-DW){1'b0}}, root_ff[DW]}) ? {1'b0, root_ff[DW]} + 1'b1
                                                        : {1'b0, root_ff[DW]};
      out_in = (up[DW:DW-1] != 2'b00) ? {(DW-1){1'b1}} : up[DW-2:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         x_ff[0]    <= radicand;
         for (int k = 0; k < DW; k++) begin
            rem_ff[k+1]  <= rem_in[k];
            root_ff[k+1] <= root_in[k];
            x_ff[k+1]    <= x_in[k];
         end
         out_ff <= out_in;
      end
   end

   assign root = out_ff;

endmodule

/* src/wall_shear_stress_projection.sv */
// Top level of the wall shear stress projection pipeline.
// Depends on wss_pkg, wss_front, wss_div and wss_sqrt.
//
//   channel | direction | handshake        | word
//   req     | in        | req_valid/stall  | normal x/y/z, load x/y/z (signed Q16.16)
//   rsp     | out       | rsp_valid/stall  | normal load x/y/z, shear x/y/z, magnitude, flag
//
// Throughput is one word per cycle unless rsp stalls; the path holds 6 front-end stages,
// 35 in the bit-per-stage dividers, 5 shear stages, 34 in the bit-per-stage
// square root and the output register.
// Reset (synchronous, active high) clears the valid bits only; payload is not reset.
// A stall on rsp with a word waiting freezes the whole pipeline and raises req_stall
// in the same cycle; nothing moves, so no word is dropped or repeated.
module wall_shear_stress_projection
   import wss_pkg::*;
(
   input  logic          clock,
   input  logic          reset,

   input  logic          req_valid,
   output logic          req_stall,
   input  word_type      req_normal_x,
   input  word_type      req_normal_y,
   input  word_type      req_normal_z,
   input  word_type      req_load_x,
   input  word_type      req_load_y,
   input  word_type      req_load_z,

   output logic          rsp_valid,
   input  logic          rsp_stall,
   output word_type      rsp_normal_load_x,
   output word_type      rsp_normal_load_y,
   output word_type      rsp_normal_load_z,
   output word_type      rsp_shear_x,
   output word_type      rsp_shear_y,
   output word_type      rsp_shear_z,
   output logic [DW-2:0] rsp_shear_magnitude,
   output logic          rsp_degenerate_normal
);

   // nl and shear values carried around the square root
   typedef struct packed {
      logic [2:0][QW:0]   nl;
      logic [2:0][QW+1:0] sh;
      logic               degen;
   } post_type;

   function automatic word_type sat_word(input logic signed [QW+1:0] v);
      if (v[QW+1:DW-1] == '0 || v[QW+1:DW-1] == '1) return v[DW-1:0];
      else if (v[QW+1]) return {1'b1, {(DW-1){1'b0}}};
      else return {1'b0, {(DW-1){1'b1}}};
   endfunction

   logic en;

   word_type normal [3];
   word_type load   [3];
   logic     fr_valid;
   num_type  fr_num [3];
   wide_type fr_s;
   meta_type fr_meta;
   quo_type  quo [3];

   logic     vdiv_ff [0:DIV_LAT-1];
   meta_type meta_ff [0:DIV_LAT-1];

   // shear stages
   logic                  v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic signed [QW:0]    nl1_ff [3];
   word_type              ld1_ff [3];
   logic                  dg1_ff;
   logic signed [QW:0]    nl2_ff [3];
   logic signed [QW+1:0]  sh2_ff [3];
   logic                  dg2_ff;
   logic [QW:0]           shm3_ff [3];
   post_type              p3_ff, p4_ff, p5_ff;
   wide_type              sq4_ff [3];
   wide_type              msq5_ff;

   logic     vsq_ff [0:SQ_LAT-1];
   post_type psq_ff [0:SQ_LAT-1];
   logic [DW-2:0] root;

   logic     rsp_valid_ff;
   word_type nl_out_ff [3];
   word_type sh_out_ff [3];
   logic [DW-2:0] mag_out_ff;
   logic     degen_out_ff;

   logic signed [QW:0]   nl1_in [3];
   logic signed [QW+1:0] sh2_in [3];
   logic [QW:0]          shm3_in [3];
   logic [PW+1:0]        tot5_in;

   // hold everything while a finished word waits on a stalled consumer
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   assign normal[0] = req_normal_x;
   assign normal[1] = req_normal_y;
   assign normal[2] = req_normal_z;
   assign load[0]   = req_load_x;
   assign load[1]   = req_load_y;
   assign load[2]   = req_load_z;

   wss_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .normal    (normal),
      .load      (load),
      .out_valid (fr_valid),
      .num       (fr_num),
      .norm_sq   (fr_s),
      .meta      (fr_meta)
   );

   for (genvar g = 0; g < 3; g++) begin : g_div
      wss_div u_div (
         .clock (clock),
         .en    (en),
         .num   (fr_num[g]),
         .den   (fr_s),
         .quo   (quo[g])
      );
   end

   wss_sqrt u_sqrt (
      .clock    (clock),
      .en       (en),
      .radicand (msq5_ff),
      .root     (root)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic signed [QW:0] q;
         q = $signed({1'b0, quo[i]});
         // a zero normal has no projection: the whole load is shear
         if (meta_ff[DIV_LAT-1].degen) nl1_in[i] = '0;
         else if (meta_ff[DIV_LAT-1].d_neg ^ meta_ff[DIV_LAT-1].n_neg[i]) nl1_in[i] = -q;
         else nl1_in[i] = q;

         sh2_in[i]  = (QW+2)'(ld1_ff[i]) - (QW+2)'(nl1_ff[i]);
         shm3_in[i] = sh2_ff[i][QW+1] ? (QW+1)'(-sh2_ff[i]) : (QW+1)'(sh2_ff[i]);
      end
      tot5_in = (PW+2)'(sq4_ff[0]) + (PW+2)'(sq4_ff[1]) + (PW+2)'(sq4_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_LAT; k++) vdiv_ff[k] <= 1'b0;
         for (int k = 0; k < SQ_LAT; k++) vsq_ff[k] <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vdiv_ff[0] <= fr_valid;
         for (int k = 1; k < DIV_LAT; k++) vdiv_ff[k] <= vdiv_ff[k-1];
         v1_ff <= vdiv_ff[DIV_LAT-1];
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         vsq_ff[0] <= v5_ff;
         for (int k = 1; k < SQ_LAT; k++) vsq_ff[k] <= vsq_ff[k-1];
         rsp_valid_ff <= vsq_ff[SQ_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // align side data with the divider
         meta_ff[0] <= fr_meta;
         for (int k = 1; k < DIV_LAT; k++) meta_ff[k] <= meta_ff[k-1];

         for (int i = 0; i < 3; i++) begin
            nl1_ff[i]  <= nl1_in[i];
            ld1_ff[i]  <= meta_ff[DIV_LAT-1].ld[i];
            nl2_ff[i]  <= nl1_ff[i];
            sh2_ff[i]  <= sh2_in[i];
            shm3_ff[i] <= shm3_in[i];
            p3_ff.nl[i] <= nl2_ff[i];
            p3_ff.sh[i] <= sh2_ff[i];
            sq4_ff[i]  <= wide_type'(shm3_ff[i]) * wide_type'(shm3_ff[i]);
         end
         dg1_ff   <= meta_ff[DIV_LAT-1].degen;
         dg2_ff   <= dg1_ff;
         p3_ff.degen <= dg2_ff;
         p4_ff    <= p3_ff;
         p5_ff    <= p4_ff;
         msq5_ff  <= (tot5_in[PW+1:PW] != 2'b00) ? '1 : tot5_in[PW-1:0];

         psq_ff[0] <= p5_ff;
         for (int k = 1; k < SQ_LAT; k++) psq_ff[k] <= psq_ff[k-1];

         for (int i = 0; i < 3; i++) begin
            nl_out_ff[i] <= sat_word((QW+2)'($signed(psq_ff[SQ_LAT-1].nl[i])));
            sh_out_ff[i] <= sat_word($signed(psq_ff[SQ_LAT-1].sh[i]));
         end
         mag_out_ff   <= root;
         degen_out_ff <= psq_ff[SQ_LAT-1].degen;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_normal_load_x     = nl_out_ff[0];
   assign rsp_normal_load_y     = nl_out_ff[1];
   assign rsp_normal_load_z     = nl_out_ff[2];
   assign rsp_shear_x           = sh_out_ff[0];
   assign rsp_shear_y           = sh_out_ff[1];
   assign rsp_shear_z           = sh_out_ff[2];
   assign rsp_shear_magnitude   = mag_out_ff;
   assign rsp_degenerate_normal = degen_out_ff;

endmodule

/* src/wss_checker.sv */
// Port-level checks for the wall shear stress projection block, bound to its top level.
// Depends on wss_pkg and wall_shear_stress_projection.
module wss_port_checker
   import wss_pkg::*;
(
   input logic          clock,
   input logic          reset,
   input logic          req_valid,
   input logic          req_stall,
   input logic          rsp_valid,
   input logic          rsp_stall,
   input word_type      rsp_normal_load_x,
   input word_type      rsp_normal_load_y,
   input word_type      rsp_normal_load_z,
   input word_type      rsp_shear_x,
   input logic [DW-2:0] rsp_shear_magnitude,
   input logic          rsp_degenerate_normal
);

   // a waiting word holds while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_shear_x)
                                 && $stable(rsp_shear_magnitude))
      else $error("stalled response word changed");

   // with no word waiting the pipeline never pushes back
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while output is free");

   // a zero normal gives no normal load
   a_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate_normal |-> rsp_normal_load_x == '0
         && rsp_normal_load_y == '0 && rsp_normal_load_z == '0)
      else $error("degenerate normal with nonzero normal load");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind wall_shear_stress_projection wss_port_checker u_wss_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_valid),
   .req_stall             (req_stall),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_normal_load_x     (rsp_normal_load_x),
   .rsp_normal_load_y     (rsp_normal_load_y),
   .rsp_normal_load_z     (rsp_normal_load_z),
   .rsp_shear_x           (rsp_shear_x),
   .rsp_shear_magnitude   (rsp_shear_magnitude),
   .rsp_degenerate_normal (rsp_degenerate_normal)
);

/* tb/wss_checker.sv */
// Watches both channels of the wall shear stress projection, predicts every result word
// and compares it with the block's output. Depends on wss_pkg for the component types.
module wss_checker
   import wss_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_stall,
   input  word_type      req_normal_x,
   input  word_type      req_normal_y,
   input  word_type      req_normal_z,
   input  word_type      req_load_x,
   input  word_type      req_load_y,
   input  word_type      req_load_z,
   input  logic          rsp_valid,
   input  logic          rsp_stall,
   input  word_type      rsp_normal_load_x,
   input  word_type      rsp_normal_load_y,
   input  word_type      rsp_normal_load_z,
   input  word_type      rsp_shear_x,
   input  word_type      rsp_shear_y,
   input  word_type      rsp_shear_z,
   input  logic [DW-2:0] rsp_shear_magnitude,
   input  logic          rsp_degenerate_normal,
   output int            errors,
   output int            pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [2:0][DW-1:0] nl;
      logic [2:0][DW-1:0] sh;
      logic [DW-2:0]      mag;
      logic               degen;
   } projection_type;

   projection_type projection_q[$];

   function automatic logic [31:0] clamp32(longint signed v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   function automatic logic [63:0] root_round(logic [63:0] s);
      logic [63:0] r, b, x;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      x = s;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      if (x > r) r = r + 1;
      return r;
   endfunction

   function automatic projection_type project(word_type nx, word_type ny, word_type nz,
                                              word_type lx, word_type ly, word_type lz);
      projection_type  res;
      longint signed   n[3], l[3], nl[3], sh[3];
      logic [63:0]     an[3], s, pos, neg, dmag, msq, sq, p, m;
      logic [64:0]     acc;
      logic [127:0]    num, q, rem;
      logic            dneg;
      n[0] = nx; n[1] = ny; n[2] = nz;
      l[0] = lx; l[1] = ly; l[2] = lz;
      s = 0; pos = 0; neg = 0; msq = 0;
      for (int i = 0; i < 3; i++) begin
         an[i] = (n[i] < 0) ? -n[i] : n[i];
         p = an[i] * ((l[i] < 0) ? -l[i] : l[i]);
         s = s + an[i] * an[i];
         if ((n[i] < 0) != (l[i] < 0)) neg = neg + p;
         else pos = pos + p;
      end
      dneg = neg > pos;
      dmag = dneg ? neg - pos : pos - neg;
      for (int i = 0; i < 3; i++) begin
         nl[i] = 0;
         if (s != 0) begin
            num = {64'd0, dmag} * {64'd0, an[i]};
            q = num / {64'd0, s};
            rem = num % {64'd0, s};
            if (rem >= {64'd0, s} - rem) q = q + 1;
            nl[i] = (dneg != (n[i] < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
         end
         sh[i] = l[i] - nl[i];
         // squares wrap at 64 bits, the running sum saturates
         p = (sh[i] < 0) ? -sh[i] : sh[i];
         sq = p * p;
         acc = {1'b0, msq} + {1'b0, sq};
         msq = acc[64] ? 64'hffff_ffff_ffff_ffff : acc[63:0];
      end
      m = root_round(msq);
      if (m > 64'h7fff_ffff) m = 64'h7fff_ffff;
      for (int i = 0; i < 3; i++) begin
         res.nl[i] = clamp32(nl[i]);
         res.sh[i] = clamp32(sh[i]);
      end
      res.mag = m[30:0];
      res.degen = (s == 0);
      return res;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t mismatch %s expected %h actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   assign pending = projection_q.size();

   initial errors = 0;

   always @(posedge clock) begin
      projection_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            projection_q.push_back(project(req_normal_x, req_normal_y, req_normal_z,
                                           req_load_x, req_load_y, req_load_z));
         if (rsp_valid && !rsp_stall) begin
            if (projection_q.size() == 0) begin
               $display("%0t mismatch unexpected word expected none actual %h", $time,
                        rsp_shear_magnitude);
               errors++;
            end else begin
               want = projection_q.pop_front();
               check_field("normal_load_x", want.nl[0], rsp_normal_load_x);
               check_field("normal_load_y", want.nl[1], rsp_normal_load_y);
               check_field("normal_load_z", want.nl[2], rsp_normal_load_z);
               check_field("shear_x", want.sh[0], rsp_shear_x);
               check_field("shear_y", want.sh[1], rsp_shear_y);
               check_field("shear_z", want.sh[2], rsp_shear_z);
               check_field("shear_magnitude", {1'b0, want.mag}, {1'b0, rsp_shear_magnitude});
               check_field("degenerate_normal", {31'd0, want.degen},
                           {31'd0, rsp_degenerate_normal});
            end
         end
      end
   end

endmodule

/* tb/tb.sv */
// Top of the wall shear stress projection testbench: clock, reset, stimulus and verdict.
// Depends on wss_pkg, the block and wss_checker, which does all the prediction.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import wss_pkg::*;

   localparam int RANDOM_WORDS = 850;
   localparam int DRAIN_CYCLES = 200;   // comfortably above the pipeline latency

   logic          clock = 0;
   logic          reset = 1;
   logic          req_valid = 0;
   logic          req_stall;
   word_type      req_normal_x = 0, req_normal_y = 0, req_normal_z = 0;
   word_type      req_load_x = 0, req_load_y = 0, req_load_z = 0;
   logic          rsp_valid;
   logic          rsp_stall = 0;
   word_type      rsp_normal_load_x, rsp_normal_load_y, rsp_normal_load_z;
   word_type      rsp_shear_x, rsp_shear_y, rsp_shear_z;
   logic [DW-2:0] rsp_shear_magnitude;
   logic          rsp_degenerate_normal;
   int            errors, pending;
   int            sent = 0;

   always #4 clock = ~clock;

   wall_shear_stress_projection dut (.*);

   wss_checker u_checker (.*);

   // Pick one component: often full random or small, sometimes an extreme, zero or near one.
   function automatic word_type pick_component();
      case ($urandom_range(0, 9))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return 0;
         3, 4, 5: return $signed($urandom_range(0, 32'h001fffff)) - 32'sh00100000;
         6: return $signed($urandom_range(0, 32'h1ffff)) - 32'sh10000; // within plus or minus one
         default: return $urandom;
      endcase
   endfunction

   // Drive one word and hold it until the block takes it.
   task automatic offer(word_type nx, word_type ny, word_type nz,
                        word_type lx, word_type ly, word_type lz);
      req_valid    <= 1;
      req_normal_x <= nx;
      req_normal_y <= ny;
      req_normal_z <= nz;
      req_load_x   <= lx;
      req_load_y   <= ly;
      req_load_z   <= lz;
      // stall only moves at rising edges, so read it mid-cycle
      forever begin
         @(negedge clock);
         if (!req_stall) break;
      end
      @(posedge clock);
      sent++;
   endtask

   // Insert a random gap before the next burst.
   task automatic idle_gap();
      int gap;
      gap = $urandom_range(1, 12);
      req_valid <= 0;
      repeat (gap) @(posedge clock);
   endtask

   // Receiver: one of four stall patterns, re-chosen at random periodically, plus one long hold-off.
   initial begin
      int cycle, hold, mode;
      cycle = 0;
      hold = 0;
      mode = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         cycle++;
         if (cycle == 300) hold = 400;
         if (cycle % 64 == 0) mode = $urandom_range(0, 3);
         if (hold > 0) begin
            rsp_stall <= 1;
            hold--;
         end else begin
            case (mode)
               0: rsp_stall <= 0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= cycle[2];
            endcase
         end
      end
   end

   initial begin
      #5ms;
      $display("FAIL wall_shear_stress_projection");
      $finish;
   end

   initial begin
      int burst, waited;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: zero normal, axis normals, extremes, parallel and orthogonal loads
      offer(0, 0, 0, 32'sh00010000, -32'sh00020000, 32'sh00030000);
      offer(0, 0, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
      offer(0, 0, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000);
      offer(0, 0, 0, 0, 0, 0);
      offer(32'sh00010000, 0, 0, 32'sh00050000, 32'sh00030000, -32'sh00010000);
      offer(0, -32'sh00010000, 0, 32'sh00050000, 32'sh00030000, -32'sh00010000);
      offer(0, 0, 32'sh00000001, 32'sh00050000, 32'sh00030000, -32'sh00010000);
      offer(32'sh00010000, 32'sh00010000, 32'sh00010000,
            32'sh00020000, 32'sh00020000, 32'sh00020000);
      offer(32'sh00010000, -32'sh00010000, 0, 32'sh00010000, 32'sh00010000, 0);
      offer(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
            32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
      offer(32'sh80000000, 32'sh80000000, 32'sh80000000,
            32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
      offer(32'sh80000000, 32'sh80000000, 32'sh80000000,
            32'sh80000000, 32'sh80000000, 32'sh80000000);
      offer(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
            32'sh80000000, 32'sh7fffffff, 32'sh80000000);
      offer(32'sh00000001, 0, 0, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
      offer(32'sh00000001, 32'sh00000001, 0, 32'sh7fffffff, 32'sh80000000, 0);
      offer(32'sh00000001, 32'sh7fffffff, 32'sh80000000,
            32'sh00000001, -32'sh00000001, 32'sh00000001);
      offer(-32'sh00000001, -32'sh00000001, -32'sh00000001, 1, 1, 1);
      offer(32'sh00030000, 32'sh00040000, 0, 32'sh00040000, -32'sh00030000, 32'sh7fffffff);
      idle_gap();

      // random: bursts of words separated by gaps
      while (sent < RANDOM_WORDS + 18) begin
         burst = $urandom_range(1, 40);
         repeat (burst) begin
            if ($urandom_range(0, 19) == 0)
               offer(0, 0, 0, pick_component(), pick_component(), pick_component());
            else
               offer(pick_component(), pick_component(), pick_component(),
                     pick_component(), pick_component(), pick_component());
         end
         idle_gap();
      end
      req_valid <= 0;

      waited = 0;
      while (pending != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("PASS wall_shear_stress_projection");
      else
         $display("FAIL wall_shear_stress_projection");
      $finish;
   end

endmodule

/* files.f */
src/wss_pkg.sv
src/wss_front.sv
src/wss_div.sv
src/wss_sqrt.sv
src/wall_shear_stress_projection.sv
src/wss_checker.sv
tb/wss_checker.sv
tb/tb.sv
